FILE: src/stis_pkg.sv
// Shared types and constants for the sorted table interpolation search core.
`default_nettype none
package stis_pkg;
	localparam int TABLE_DEPTH_DEF = 256;
	localparam int KEY_W = 31;
	localparam int GRADE_W = 8;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_SEARCH = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INS_SCAN, S_INS_SCAN_W, S_INS_SHIFT_RD, S_INS_SHIFT_W, S_INS_PUT,
		S_REM_RD, S_REM_W,
		S_SR_RDLO, S_SR_RDHI, S_SR_WLO, S_SR_DIV, S_SR_RDP, S_SR_WP,
		S_SR_CMP, S_SR_GRD,
		S_DONE
	} state_t;

	// Command bundle from controller to datapath.
	typedef struct packed {
		logic latch_in;     // capture request
		logic rd_ptr;       // read at ptr
		logic rd_lo;        // read at lo
		logic rd_hi;        // read at hi
		logic rd_pos;       // read at probe pos
		logic wr_ptr1;      // write ptr+1 <- read data
		logic wr_at;        // write request at ptr
		logic wr_compact;   // write wr <- read data
		logic ptr_clr;
		logic ptr_inc;
		logic ptr_dec;
		logic ptr_cnt;      // ptr <- count
		logic wr_inc;
		logic cap_klo;
		logic cap_khi;
		logic srch_init;
		logic div_start;
		logic div_step;
		logic go_hi;        // lo <- pos+1
		logic go_lo;        // hi <- pos-1
		logic hit_mark;
		logic cnt_inc;
		logic cnt_from_wr;
		logic res_ok;
		logic res_miss;
		logic res_full;
		logic res_ins;
		logic res_rem;
		logic res_found;
	} ctl_t;

	// Status bundle from datapath to controller.
	typedef struct packed {
		logic [1:0] cmd;
		logic       full;
		logic       ptr_lt_cnt;
		logic       ptr_gt_zero;
		logic       ptr_gt_at;
		logic       rd_le_key;
		logic       rd_eq_key;
		logic       rd_lt_key;
		logic       lo_le_hi;
		logic       out_range;
		logic       keys_eq;
		logic       div_done;
		logic       hit;
	} sts_t;
endpackage
`default_nettype wire

FILE: src/stis_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module stis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

FILE: src/stis_ctrl.sv
// Controller state machine for insert, remove and search sequences.
`default_nettype none
module stis_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire stis_pkg::sts_t  sts,
	output stis_pkg::ctl_t       ctl
);
	stis_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stis_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			stis_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.latch_in = 1'b1;
					ctl.ptr_clr = 1'b1;
					case (sts.cmd)
						stis_pkg::CMD_INSERT: state_d = stis_pkg::S_INS_SCAN;
						stis_pkg::CMD_REMOVE: state_d = stis_pkg::S_REM_RD;
						stis_pkg::CMD_SEARCH: state_d = stis_pkg::S_SR_RDLO;
						default: begin
							ctl.res_miss = 1'b1;
							state_d = stis_pkg::S_DONE;
						end
					endcase
				end
			end
			// insert: find first entry with key greater than request
			stis_pkg::S_INS_SCAN: begin
				if (sts.full) begin
					ctl.res_full = 1'b1;
					state_d = stis_pkg::S_DONE;
				end else if (sts.ptr_lt_cnt) begin
					ctl.rd_ptr = 1'b1;
					state_d = stis_pkg::S_INS_SCAN_W;
				end else begin
					ctl.ptr_cnt = 1'b1;
					state_d = stis_pkg::S_INS_SHIFT_RD;
				end
			end
			stis_pkg::S_INS_SCAN_W: begin
				if (sts.rd_le_key) begin
					ctl.ptr_inc = 1'b1;
					state_d = stis_pkg::S_INS_SCAN;
				end else begin
					ctl.ptr_cnt = 1'b1;
					state_d = stis_pkg::S_INS_SHIFT_RD;
				end
			end
			// shift entries [at, count) up by one, from the top
			stis_pkg::S_INS_SHIFT_RD: begin
				if (sts.ptr_gt_at) begin
					ctl.ptr_dec = 1'b1;
					ctl.rd_ptr = 1'b1;
					state_d = stis_pkg::S_INS_SHIFT_W;
				end else begin
					state_d = stis_pkg::S_INS_PUT;
				end
			end
			stis_pkg::S_INS_SHIFT_W: begin
				ctl.wr_ptr1 = 1'b1;
				state_d = stis_pkg::S_INS_SHIFT_RD;
			end
			stis_pkg::S_INS_PUT: begin
				ctl.wr_at = 1'b1;
				ctl.cnt_inc = 1'b1;
				ctl.res_ins = 1'b1;
				state_d = stis_pkg::S_DONE;
			end
			// remove: compact in one pass
			stis_pkg::S_REM_RD: begin
				if (sts.ptr_lt_cnt) begin
					ctl.rd_ptr = 1'b1;
					state_d = stis_pkg::S_REM_W;
				end else begin
					ctl.cnt_from_wr = 1'b1;
					ctl.res_rem = 1'b1;
					state_d = stis_pkg::S_DONE;
				end
			end
			stis_pkg::S_REM_W: begin
				if (sts.rd_eq_key) begin
					ctl.hit_mark = 1'b1;
				end else begin
					ctl.wr_compact = 1'b1;
					ctl.wr_inc = 1'b1;
				end
				ctl.ptr_inc = 1'b1;
				state_d = stis_pkg::S_REM_RD;
			end
			// search
			stis_pkg::S_SR_RDLO: begin
				if (sts.lo_le_hi) begin
					ctl.rd_lo = 1'b1;
					state_d = stis_pkg::S_SR_RDHI;
				end else begin
					ctl.res_miss = 1'b1;
					state_d = stis_pkg::S_DONE;
				end
			end
			// key at lo arrives here while hi is read
			stis_pkg::S_SR_RDHI: begin
				ctl.rd_hi = 1'b1;
				ctl.cap_klo = 1'b1;
				state_d = stis_pkg::S_SR_WLO;
			end
			stis_pkg::S_SR_WLO: begin
				ctl.cap_khi = 1'b1;
				ctl.div_start = 1'b1;
				state_d = stis_pkg::S_SR_DIV;
			end
			stis_pkg::S_SR_DIV: begin
				if (sts.out_range) begin
					ctl.res_miss = 1'b1;
					state_d = stis_pkg::S_DONE;
				end else if (sts.keys_eq || sts.div_done) begin
					state_d = stis_pkg::S_SR_RDP;
				end else begin
					ctl.div_step = 1'b1;
				end
			end
			stis_pkg::S_SR_RDP: begin
				ctl.rd_pos = 1'b1;
				state_d = stis_pkg::S_SR_WP;
			end
			stis_pkg::S_SR_WP: begin
				ctl.rd_pos = 1'b1;
				state_d = stis_pkg::S_SR_CMP;
			end
			stis_pkg::S_SR_CMP: begin
				if (sts.rd_eq_key) begin
					ctl.rd_pos = 1'b1;
					state_d = stis_pkg::S_SR_GRD;
				end else begin
					if (sts.rd_lt_key) begin
						ctl.go_hi = 1'b1;
					end else begin
						ctl.go_lo = 1'b1;
					end
					state_d = stis_pkg::S_SR_RDLO;
				end
			end
			stis_pkg::S_SR_GRD: begin
				ctl.res_found = 1'b1;
				state_d = stis_pkg::S_DONE;
			end
			stis_pkg::S_DONE: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = stis_pkg::S_IDLE;
				end
			end
			default: state_d = stis_pkg::S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

FILE: src/stis_dp.sv
// Datapath: record stores, pointers, probe divider and result registers.
`default_nettype none
module stis_dp #(
	parameter int TABLE_DEPTH = stis_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [1:0]                   command,
	input  wire logic [stis_pkg::KEY_W-1:0]   key,
	input  wire logic [stis_pkg::GRADE_W-1:0] grade,
	input  wire stis_pkg::ctl_t               ctl,
	output stis_pkg::sts_t                    sts,
	output logic [1:0]                        status,
	output logic [7:0]                        position,
	output logic [7:0]                        found_grade,
	output logic [8:0]                        occupancy
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = AW + 1;               // sign bit index; signed indices are SW+1 bits
	localparam int NW = stis_pkg::KEY_W + AW; // product width
	localparam int DCW = $clog2(NW + 1);

	logic [stis_pkg::KEY_W-1:0] key_q, klo_q, khi_q;
	logic [stis_pkg::GRADE_W-1:0] grade_q;
	logic [CW-1:0] cnt_q, ptr_q, wr_q, at_q;
	logic signed [SW:0] lo_q, hi_q;
	logic [AW-1:0] pos_q;
	logic hit_q;
	logic [AW-1:0] first_q;

	// RAM ports
	logic [AW-1:0] addr;
	logic we;
	logic [stis_pkg::KEY_W-1:0] k_wd, k_rd;
	logic [stis_pkg::GRADE_W-1:0] g_wd, g_rd;

	stis_ram #(.WIDTH(stis_pkg::KEY_W), .DEPTH(TABLE_DEPTH)) u_keys (
		.clk(clk), .we(we), .addr(addr), .wdata(k_wd), .rdata(k_rd)
	);
	stis_ram #(.WIDTH(stis_pkg::GRADE_W), .DEPTH(TABLE_DEPTH)) u_grades (
		.clk(clk), .we(we), .addr(addr), .wdata(g_wd), .rdata(g_rd)
	);

	always_comb begin
		we = ctl.wr_ptr1 | ctl.wr_at | ctl.wr_compact;
		k_wd = k_rd;
		g_wd = g_rd;
		addr = ptr_q[AW-1:0];
		if (ctl.wr_at) begin
			k_wd = key_q;
			g_wd = grade_q;
		end
		if (ctl.wr_ptr1) begin
			addr = AW'(ptr_q + CW'(1));
		end else if (ctl.ptr_dec) begin
			addr = AW'(ptr_q - CW'(1));
		end else if (ctl.wr_compact) begin
			addr = wr_q[AW-1:0];
		end else if (ctl.rd_lo) begin
			addr = lo_q[AW-1:0];
		end else if (ctl.rd_hi) begin
			addr = hi_q[AW-1:0];
		end else if (ctl.rd_pos) begin
			addr = pos_q;
		end
	end

	// restoring divider: quotient = (key-klo)*(hi-lo) / (khi-klo)
	logic [NW-1:0] num_q, quo_q;
	logic [stis_pkg::KEY_W:0] rem_q;
	logic [stis_pkg::KEY_W-1:0] den;
	logic [DCW-1:0] dcnt_q;
	logic [stis_pkg::KEY_W:0] rem_sh;
	logic signed [SW:0] span, probe;

	assign den = khi_q - klo_q;
	assign span = hi_q - lo_q;
	assign rem_sh = {rem_q[stis_pkg::KEY_W-1:0], num_q[NW-1]};
	assign probe = lo_q + (SW+1)'(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.cnt_inc) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (ctl.cnt_from_wr) begin
			cnt_q <= wr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch_in) begin
			key_q <= key;
			grade_q <= grade;
			wr_q <= '0;
			hit_q <= 1'b0;
			first_q <= '0;
			lo_q <= '0;
			hi_q <= (SW+1)'(cnt_q) - (SW+1)'(1);
		end
		if (ctl.ptr_clr) ptr_q <= '0;
		if (ctl.ptr_inc) ptr_q <= ptr_q + CW'(1);
		if (ctl.ptr_dec) ptr_q <= ptr_q - CW'(1);
		if (ctl.ptr_cnt) begin
			ptr_q <= cnt_q;
			at_q <= ptr_q;
		end
		if (ctl.wr_inc) wr_q <= wr_q + CW'(1);
		if (ctl.hit_mark) begin
			hit_q <= 1'b1;
			if (!hit_q) first_q <= ptr_q[AW-1:0];
		end
		if (ctl.cap_klo) klo_q <= k_rd;
		if (ctl.cap_khi) begin
			khi_q <= k_rd;
			// one multiply, registered
			num_q <= NW'(key_q - klo_q) * NW'(span[AW-1:0]);
			rem_q <= '0;
			quo_q <= '0;
			dcnt_q <= '0;
		end
		if (ctl.div_step) begin
			num_q <= num_q << 1;
			if (rem_sh >= {1'b0, den}) begin
				rem_q <= rem_sh - {1'b0, den};
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q + DCW'(1);
		end
		if (sts.keys_eq && !sts.out_range) pos_q <= lo_q[AW-1:0];
		else if (sts.div_done) pos_q <= probe[AW-1:0];
		if (ctl.go_hi) lo_q <= (SW+1)'(pos_q) + (SW+1)'(1);
		if (ctl.go_lo) hi_q <= (SW+1)'(pos_q) - (SW+1)'(1);
	end

	// klo is captured in S_SR_RDHI, khi in S_SR_WLO; both bounds are valid from S_SR_DIV on
	always_comb begin
		sts = '0;
		sts.cmd = command;
		sts.full = cnt_q >= CW'(TABLE_DEPTH);
		sts.ptr_lt_cnt = ptr_q < cnt_q;
		sts.ptr_gt_zero = ptr_q != '0;
		sts.ptr_gt_at = ptr_q > at_q;
		sts.rd_le_key = k_rd <= key_q;
		sts.rd_eq_key = k_rd == key_q;
		sts.rd_lt_key = k_rd < key_q;
		sts.lo_le_hi = lo_q <= hi_q;
		sts.out_range = (key_q < klo_q) || (key_q > khi_q);
		sts.keys_eq = khi_q == klo_q;
		sts.div_done = dcnt_q == DCW'(NW);
		sts.hit = hit_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.res_ok || ctl.res_miss || ctl.res_full) begin
			status <= ctl.res_full ? stis_pkg::ST_FULL : stis_pkg::ST_MISS;
			position <= '0;
			found_grade <= '0;
		end
		if (ctl.res_ins) begin
			status <= stis_pkg::ST_OK;
			position <= 8'(at_q);
			found_grade <= '0;
		end
		if (ctl.res_rem) begin
			status <= hit_q ? stis_pkg::ST_OK : stis_pkg::ST_MISS;
			position <= hit_q ? 8'(first_q) : '0;
			found_grade <= '0;
		end
		if (ctl.res_found) begin
			status <= stis_pkg::ST_OK;
			position <= 8'(pos_q);
			found_grade <= g_rd;
		end
	end

	assign occupancy = 9'(cnt_q);
endmodule
`default_nettype wire

FILE: src/sorted_table_interpolation_search_core.sv
// Top level of the sorted table interpolation search core.
// Keeps up to TABLE_DEPTH (key, grade) records sorted by key in two single-port
// RAMs and runs one request at a time. Insert scans up to the insert point and
// shifts the tail up. Remove compacts in one pass. Each search probe reads both
// bounds, multiplies once and, unless the bound keys are equal, runs a restoring
// divider of 31+log2(depth) steps. Results are held until taken; the next request
// is accepted after that.
`default_nettype none
module sorted_table_interpolation_search_core #(
	parameter int TABLE_DEPTH = stis_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   command,
	input  wire logic [stis_pkg::KEY_W-1:0]   key,
	input  wire logic [stis_pkg::GRADE_W-1:0] grade,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [1:0]                        status,
	output logic [7:0]                        position,
	output logic [7:0]                        found_grade,
	output logic [8:0]                        occupancy
);
	stis_pkg::ctl_t ctl;
	stis_pkg::sts_t sts;

	stis_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .ctl(ctl)
	);

	stis_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .command(command), .key(key), .grade(grade),
		.ctl(ctl), .sts(sts), .status(status), .position(position),
		.found_grade(found_grade), .occupancy(occupancy)
	);
endmodule
`default_nettype wire
